>>> hdl/rigid_frame_vector_transform_unit_defines.svh
// Assertion macros for the checker file of the vector transform unit.
// Depends on nothing; take it in with a bare include.
`ifndef RIGID_FRAME_VECTOR_TRANSFORM_UNIT_DEFINES_SVH
`define RIGID_FRAME_VECTOR_TRANSFORM_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RFVT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RFVT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/rfvt_pkg.sv
// Shared types and constants of the rigid frame vector transform unit.
// Depends on nothing.
`timescale 1ns / 1ps

package rfvt_pkg;

  localparam int unsigned AXIS_COMP_BITS = 16;
  localparam int unsigned AXIS_REG_BITS  = 3 * AXIS_COMP_BITS;
  localparam int unsigned APB_DATA_BITS  = 64;
  localparam int unsigned APB_ADDR_BITS  = 6;
  localparam int unsigned RFVT_PIPE_DEPTH = 4;

  localparam logic [AXIS_REG_BITS-1:0] AXIS_ONE_RST   = 48'h0000_0000_4000;
  localparam logic [AXIS_REG_BITS-1:0] AXIS_TWO_RST   = 48'h0000_4000_0000;
  localparam logic [AXIS_REG_BITS-1:0] AXIS_THREE_RST = 48'h4000_0000_0000;

  typedef enum logic [1:0] {
    OP_ROT_LOCAL    = 2'd0,
    OP_XFORM_LOCAL  = 2'd1,
    OP_ROT_PARENT   = 2'd2,
    OP_XFORM_PARENT = 2'd3
  } rfvt_op_e;

  typedef enum logic [2:0] {
    REG_ORIGIN_X   = 3'd0,
    REG_ORIGIN_Y   = 3'd1,
    REG_ORIGIN_Z   = 3'd2,
    REG_AXIS_ONE   = 3'd3,
    REG_AXIS_TWO   = 3'd4,
    REG_AXIS_THREE = 3'd5
  } rfvt_reg_e;

  typedef struct packed {
    logic valid;
    logic add_org;
  } rfvt_ctl_t;

endpackage

>>> hdl/rfvt_cfg.sv
// APB register file: frame origin and three packed Q2.14 axes.
// Depends on rfvt_pkg.
`timescale 1ns / 1ps

module rfvt_cfg import rfvt_pkg::*; #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel_i,
  input  logic                                penable_i,
  input  logic                                pwrite_i,
  input  logic [APB_ADDR_BITS-1:0]            paddr_i,
  input  logic [APB_DATA_BITS-1:0]            pwdata_i,
  output logic [APB_DATA_BITS-1:0]            prdata_o,
  output logic [2:0][COORD_BITS-1:0]          origin_o,
  output logic [2:0][AXIS_REG_BITS-1:0]       axis_o
);

  rfvt_reg_e                        reg_idx;
  logic                             wr_en;
  logic [2:0][COORD_BITS-1:0]       origin_q;
  logic [2:0][AXIS_REG_BITS-1:0]    axis_q;

  assign reg_idx = rfvt_reg_e'(paddr_i[APB_ADDR_BITS-1:3]);
  assign wr_en   = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q <= '0;
      axis_q[0] <= AXIS_ONE_RST;
      axis_q[1] <= AXIS_TWO_RST;
      axis_q[2] <= AXIS_THREE_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ORIGIN_X:   origin_q[0] <= pwdata_i[COORD_BITS-1:0];
        REG_ORIGIN_Y:   origin_q[1] <= pwdata_i[COORD_BITS-1:0];
        REG_ORIGIN_Z:   origin_q[2] <= pwdata_i[COORD_BITS-1:0];
        REG_AXIS_ONE:   axis_q[0] <= pwdata_i[AXIS_REG_BITS-1:0];
        REG_AXIS_TWO:   axis_q[1] <= pwdata_i[AXIS_REG_BITS-1:0];
        REG_AXIS_THREE: axis_q[2] <= pwdata_i[AXIS_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ORIGIN_X:   prdata_o = APB_DATA_BITS'(origin_q[0]);
      REG_ORIGIN_Y:   prdata_o = APB_DATA_BITS'(origin_q[1]);
      REG_ORIGIN_Z:   prdata_o = APB_DATA_BITS'(origin_q[2]);
      REG_AXIS_ONE:   prdata_o = APB_DATA_BITS'(axis_q[0]);
      REG_AXIS_TWO:   prdata_o = APB_DATA_BITS'(axis_q[1]);
      REG_AXIS_THREE: prdata_o = APB_DATA_BITS'(axis_q[2]);
      default:        prdata_o = '0;
    endcase
  end

  assign origin_o = origin_q;
  assign axis_o   = axis_q;

endmodule

>>> hdl/rfvt_prep.sv
// Stage one: origin subtraction and selection of axis rows or columns.
// Depends on rfvt_pkg.
`timescale 1ns / 1ps

module rfvt_prep import rfvt_pkg::*; #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           valid_i,
  output logic                                           ready_o,
  input  rfvt_op_e                                       op_i,
  input  logic [2:0][COORD_BITS-1:0]                     vec_i,
  input  logic [COORD_BITS-1:0]                          w_i,
  input  logic [2:0][COORD_BITS-1:0]                     origin_i,
  input  logic [2:0][AXIS_REG_BITS-1:0]                  axis_i,
  input  logic                                           ready_i,
  output rfvt_ctl_t                                      ctl_o,
  output logic [2:0][COORD_BITS:0]                       d_o,
  output logic [2:0][2:0][AXIS_COMP_BITS-1:0]            coef_o,
  output logic [COORD_BITS-1:0]                          w_o
);

  logic                                      to_parent;
  logic                                      sub_org;
  rfvt_ctl_t                                 ctl_d, ctl_q;
  logic [2:0][COORD_BITS:0]                  d_d, d_q;
  logic [2:0][2:0][AXIS_COMP_BITS-1:0]       coef_d, coef_q;
  logic [COORD_BITS-1:0]                     w_q;

  assign to_parent = (op_i == OP_ROT_PARENT) || (op_i == OP_XFORM_PARENT);
  assign sub_org   = (op_i == OP_XFORM_LOCAL);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_d[i] = {vec_i[i][COORD_BITS-1], vec_i[i]}
             - (sub_org ? {origin_i[i][COORD_BITS-1], origin_i[i]} : '0);
    end
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        coef_d[k][i] = to_parent ? axis_i[i][k*AXIS_COMP_BITS +: AXIS_COMP_BITS]
                                 : axis_i[k][i*AXIS_COMP_BITS +: AXIS_COMP_BITS];
      end
    end
    ctl_d.valid   = valid_i;
    ctl_d.add_org = (op_i == OP_XFORM_PARENT);
  end

  assign ready_o = !ctl_q.valid || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (ready_o) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      d_q    <= d_d;
      coef_q <= coef_d;
      w_q    <= w_i;
    end
  end

  assign ctl_o  = ctl_q;
  assign d_o    = d_q;
  assign coef_o = coef_q;
  assign w_o    = w_q;

endmodule

>>> hdl/rfvt_mac.sv
// Stages two and three: nine products, then three sums rounded half up.
// Depends on rfvt_pkg.
`timescale 1ns / 1ps

module rfvt_mac import rfvt_pkg::*; #(
  parameter int unsigned COORD_BITS     = 32,
  parameter int unsigned AXIS_FRAC_BITS = 14
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  rfvt_ctl_t                                         ctl_i,
  output logic                                              ready_o,
  input  logic [2:0][COORD_BITS:0]                          d_i,
  input  logic [2:0][2:0][AXIS_COMP_BITS-1:0]               coef_i,
  input  logic [COORD_BITS-1:0]                             w_i,
  input  logic                                              ready_i,
  output rfvt_ctl_t                                         ctl_o,
  output logic [2:0][COORD_BITS+AXIS_COMP_BITS+2-AXIS_FRAC_BITS:0] rnd_o,
  output logic [COORD_BITS-1:0]                             w_o
);

  localparam int unsigned PW = COORD_BITS + 1 + AXIS_COMP_BITS;
  localparam int unsigned SW = PW + 2;
  localparam int unsigned RW = SW - AXIS_FRAC_BITS;
  localparam logic [SW-1:0] RND = {{(SW-1){1'b0}}, 1'b1} << (AXIS_FRAC_BITS - 1);

  rfvt_ctl_t                     ctl2_q, ctl3_q;
  logic                          rdy2, rdy3;
  logic [2:0][2:0][PW-1:0]       prod_d, prod_q;
  logic [2:0][SW-1:0]            sum_d;
  logic [2:0][RW-1:0]            rnd_d, rnd_q;
  logic [COORD_BITS-1:0]         w2_q, w3_q;

  assign rdy3    = !ctl3_q.valid || ready_i;
  assign rdy2    = !ctl2_q.valid || rdy3;
  assign ready_o = rdy2;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        prod_d[k][i] = $signed(d_i[i]) * $signed(coef_i[k][i]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_d[k] = $signed(prod_q[k][0]) + $signed(prod_q[k][1])
               + $signed(prod_q[k][2]) + $signed(RND);
      rnd_d[k] = sum_d[k][SW-1:AXIS_FRAC_BITS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl2_q <= '0;
      ctl3_q <= '0;
    end else begin
      if (rdy2) begin
        ctl2_q <= ctl_i;
      end
      if (rdy3) begin
        ctl3_q <= ctl2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && ctl_i.valid) begin
      prod_q <= prod_d;
      w2_q   <= w_i;
    end
    if (rdy3 && ctl2_q.valid) begin
      rnd_q <= rnd_d;
      w3_q  <= w2_q;
    end
  end

  assign ctl_o = ctl3_q;
  assign rnd_o = rnd_q;
  assign w_o   = w3_q;

endmodule

>>> hdl/rfvt_sat.sv
// Stage four: optional origin add, saturation and the output register.
// Depends on rfvt_pkg.
`timescale 1ns / 1ps

module rfvt_sat import rfvt_pkg::*; #(
  parameter int unsigned COORD_BITS     = 32,
  parameter int unsigned AXIS_FRAC_BITS = 14
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  rfvt_ctl_t                                         ctl_i,
  output logic                                              ready_o,
  input  logic [2:0][COORD_BITS+AXIS_COMP_BITS+2-AXIS_FRAC_BITS:0] rnd_i,
  input  logic [COORD_BITS-1:0]                             w_i,
  input  logic [2:0][COORD_BITS-1:0]                        origin_i,
  input  logic                                              ready_i,
  output logic                                              valid_o,
  output logic [2:0][COORD_BITS-1:0]                        res_o,
  output logic [COORD_BITS-1:0]                             w_o,
  output logic                                              sat_o
);

  localparam int unsigned RW = COORD_BITS + AXIS_COMP_BITS + 3 - AXIS_FRAC_BITS;
  localparam int unsigned AW = ((RW > COORD_BITS) ? RW : COORD_BITS) + 1;
  localparam logic [COORD_BITS-1:0] MAX_VAL = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] MIN_VAL = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic                             valid_q;
  logic [2:0][AW-1:0]               acc;
  logic [2:0]                       clip;
  logic [2:0][COORD_BITS-1:0]       res_d, res_q;
  logic                             sat_q;
  logic [COORD_BITS-1:0]            w_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      acc[k] = {{(AW-RW){rnd_i[k][RW-1]}}, rnd_i[k]}
             + (ctl_i.add_org ? {{(AW-COORD_BITS){origin_i[k][COORD_BITS-1]}}, origin_i[k]}
                              : '0);
      clip[k] = !((&acc[k][AW-1:COORD_BITS-1]) || !(|acc[k][AW-1:COORD_BITS-1]));
      if (clip[k]) begin
        res_d[k] = acc[k][AW-1] ? MIN_VAL : MAX_VAL;
      end else begin
        res_d[k] = acc[k][COORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && ctl_i.valid) begin
      res_q <= res_d;
      sat_q <= |clip;
      w_q   <= w_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;
  assign w_o     = w_q;
  assign sat_o   = sat_q;

endmodule

>>> hdl/rigid_frame_vector_transform_unit.sv
// Top level of the rigid frame vector transform unit.
// Depends on rfvt_pkg, rfvt_cfg, rfvt_prep, rfvt_mac and rfvt_sat.
//
//   channel   direction  transaction
//   s_axis    in         op (tuser) and vec_x/y/z/w (tdata)
//   m_axis    out        res_x/y/z/w (tdata) and saturated (tuser)
//   apb       in/out     origin_x/y/z, axis_one/two/three at 8*index
//
// One item per cycle unless m_axis stalls; items pass through the four register
// stages (prepare, multiply, sum and round, add origin and saturate).
// Reset clears every stage valid bit, zeroes the origin and loads identity axes.
// A stall at m_axis backs up one stage at a time; empty stages still take items.
`timescale 1ns / 1ps

module rigid_frame_vector_transform_unit import rfvt_pkg::*; #(
  parameter int unsigned COORD_BITS     = 32,
  parameter int unsigned AXIS_FRAC_BITS = 14
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // vec_x, vec_y, vec_z, vec_w, zero fill
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]       s_axis_tdata,
  // op
  input  logic [1:0]                              s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // res_x, res_y, res_z, res_w, zero fill
  output logic [((4*COORD_BITS+7)/8)*8-1:0]       m_axis_tdata,
  // saturated
  output logic [0:0]                              m_axis_tuser,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [APB_ADDR_BITS-1:0]                paddr,
  input  logic [APB_DATA_BITS-1:0]                pwdata,
  output logic [APB_DATA_BITS-1:0]                prdata,
  output logic                                    pready
);

  localparam int unsigned RW = COORD_BITS + AXIS_COMP_BITS + 3 - AXIS_FRAC_BITS;

  logic [2:0][COORD_BITS-1:0]                origin;
  logic [2:0][AXIS_REG_BITS-1:0]             axis;
  logic [2:0][COORD_BITS-1:0]                vec;
  rfvt_ctl_t                                 prep_ctl, mac_ctl;
  logic                                      mac_ready, sat_ready;
  logic [2:0][COORD_BITS:0]                  prep_d;
  logic [2:0][2:0][AXIS_COMP_BITS-1:0]       prep_coef;
  logic [COORD_BITS-1:0]                     prep_w, mac_w, out_w;
  logic [2:0][RW-1:0]                        mac_rnd;
  logic [2:0][COORD_BITS-1:0]                out_res;
  logic                                      out_sat;

  assign pready = 1'b1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vec[i] = s_axis_tdata[i*COORD_BITS +: COORD_BITS];
    end
  end

  rfvt_cfg #(
    .COORD_BITS (COORD_BITS)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .origin_o  (origin),
    .axis_o    (axis)
  );

  rfvt_prep #(
    .COORD_BITS (COORD_BITS)
  ) u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .op_i     (rfvt_op_e'(s_axis_tuser)),
    .vec_i    (vec),
    .w_i      (s_axis_tdata[3*COORD_BITS +: COORD_BITS]),
    .origin_i (origin),
    .axis_i   (axis),
    .ready_i  (mac_ready),
    .ctl_o    (prep_ctl),
    .d_o      (prep_d),
    .coef_o   (prep_coef),
    .w_o      (prep_w)
  );

  rfvt_mac #(
    .COORD_BITS     (COORD_BITS),
    .AXIS_FRAC_BITS (AXIS_FRAC_BITS)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (prep_ctl),
    .ready_o (mac_ready),
    .d_i     (prep_d),
    .coef_i  (prep_coef),
    .w_i     (prep_w),
    .ready_i (sat_ready),
    .ctl_o   (mac_ctl),
    .rnd_o   (mac_rnd),
    .w_o     (mac_w)
  );

  rfvt_sat #(
    .COORD_BITS     (COORD_BITS),
    .AXIS_FRAC_BITS (AXIS_FRAC_BITS)
  ) u_sat (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mac_ctl),
    .ready_o  (sat_ready),
    .rnd_i    (mac_rnd),
    .w_i      (mac_w),
    .origin_i (origin),
    .ready_i  (m_axis_tready),
    .valid_o  (m_axis_tvalid),
    .res_o    (out_res),
    .w_o      (out_w),
    .sat_o    (out_sat)
  );

  always_comb begin
    m_axis_tdata = '0;
    for (int i = 0; i < 3; i++) begin
      m_axis_tdata[i*COORD_BITS +: COORD_BITS] = out_res[i];
    end
    m_axis_tdata[3*COORD_BITS +: COORD_BITS] = out_w;
  end

  assign m_axis_tuser = out_sat;

endmodule

>>> hdl/rfvt_checker.sv
// Port-level checks of the vector transform unit, bound to the top level.
// Depends on rfvt_pkg and rigid_frame_vector_transform_unit_defines.svh.
`timescale 1ns / 1ps
`include "rigid_frame_vector_transform_unit_defines.svh"

module rfvt_checker import rfvt_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic s_tvalid_i,
  input logic s_tready_i,
  input logic m_tvalid_i,
  input logic m_tready_i
);

  localparam int unsigned CW = $clog2(RFVT_PIPE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH = CW'(RFVT_PIPE_DEPTH);

  logic          in_acc, out_acc;
  logic [CW-1:0] cnt_d, cnt_q;

  assign in_acc  = s_tvalid_i && s_tready_i;
  assign out_acc = m_tvalid_i && m_tready_i;

  always_comb begin
    cnt_d = cnt_q + CW'(in_acc) - CW'(out_acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  `RFVT_ASSERT_IMP(a_inflight_bound, clk_i, rst_ni, 1'b1, cnt_q <= DEPTH, "more transactions in flight than stages")
  `RFVT_ASSERT_IMP(a_out_has_item, clk_i, rst_ni, m_tvalid_i, cnt_q != '0, "result shown with nothing in flight")
  `RFVT_ASSERT_IMP(a_ready_not_full, clk_i, rst_ni, cnt_q < DEPTH, s_tready_i, "input stalled with a free stage")
  `RFVT_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_tvalid_i && !m_tready_i, m_tvalid_i, "result dropped while stalled")

endmodule

bind rigid_frame_vector_transform_unit rfvt_checker u_rfvt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid),
  .s_tready_i (s_axis_tready),
  .m_tvalid_i (m_axis_tvalid),
  .m_tready_i (m_axis_tready)
);
